@@ src/mrdp_pkg.sv @@
package mrdp_pkg;

    // field widths of the stream and configuration payloads
    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 9;
    localparam int VALUE_W  = 16;
    localparam int DOT_W    = 38;
    localparam int ROWF_W   = 3;
    localparam int ROWCFG_W = 4;
    localparam int LENCFG_W = 7;
    localparam int CFGIDX_W = 2;
    localparam int CFGDAT_W = 7;
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = MODE_W;
    localparam int M_DATA_W = 48;
    localparam int M_PAD_W  = M_DATA_W - DOT_W - 2 * ROWF_W;

    // defaults handed to the top level parameters
    localparam int DEF_MAX_ROWS   = 8;
    localparam int DEF_MAX_LEN    = 64;
    localparam int DEF_DATA_WIDTH = 16;

    // configuration reset values
    localparam logic [ROWCFG_W-1:0] RST_ROWS_FIRST  = ROWCFG_W'(8);
    localparam logic [ROWCFG_W-1:0] RST_ROWS_SECOND = ROWCFG_W'(8);
    localparam logic [LENCFG_W-1:0] RST_VEC_LEN     = LENCFG_W'(64);

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_FIRST  = 2'd0,
        MODE_LOAD_SECOND = 2'd1,
        MODE_COMPUTE     = 2'd2
    } mode_t;

    typedef enum logic [CFGIDX_W-1:0] {
        CFG_ROWS_FIRST    = 2'd0,
        CFG_ROWS_SECOND   = 2'd1,
        CFG_VECTOR_LENGTH = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_PUT   = 4'b1000
    } state_t;

    // control that travels alongside one operand pair
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } mac_ctrl_t;

    // width of a counter or address over n values, never below one bit
    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // zero counts as one, large counts saturate
    function automatic int unsigned clamp_cnt(input int unsigned v, input int unsigned hi);
        if (v == 0) begin
            return 1;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

endpackage

@@ src/mrdp_store.sv @@
module mrdp_store import mrdp_pkg::*; #(
    parameter int DEPTH = DEF_MAX_ROWS * DEF_MAX_LEN,
    parameter int DW    = DEF_DATA_WIDTH,
    parameter int AW    = idx_width(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/mrdp_mac.sv @@
module mrdp_mac import mrdp_pkg::*; #(
    parameter int DW = DEF_DATA_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mac_ctrl_t            ctrl_in,
    input  logic signed [DW-1:0] a,
    input  logic signed [DW-1:0] b,
    output logic [DOT_W-1:0]     acc,
    output logic                 done
);

    logic signed [2*DW-1:0] prod_reg;
    mac_ctrl_t              ctrl_reg;
    logic [DOT_W-1:0]       acc_reg, acc_next;
    logic [DOT_W-1:0]       prod_ext;
    logic                   done_reg;

    // low bits of the sign-extended product are enough for a modular sum
    assign prod_ext = DOT_W'(prod_reg);
    assign acc_next = ctrl_reg.first ? prod_ext : acc_reg + prod_ext;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
        if (ctrl_reg.vld) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            ctrl_reg <= ctrl_in;
            done_reg <= ctrl_reg.vld && ctrl_reg.last;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

@@ src/matrix_row_dot_product_engine.sv @@
// loads: one element request per cycle while no run is busy, no result, ready stays high
// compute: one shared multiply-accumulate walks vector_length elements per row pair, then
//   the pipeline drains through the store read, product and accumulator registers and the
//   result is registered once output is free; a run has rows_second * rows_first results
// the input is not ready from a compute request until its last result is registered
// reset (aresetn low, synchronous) clears control and restores 8 / 8 / 64, stores kept
module matrix_row_dot_product_engine import mrdp_pkg::*; #(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_LEN    = DEF_MAX_LEN,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input request stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // element_index[8:0], element_value[24:9], zero pad
    input  logic [S_USER_W-1:0] s_axis_tuser,   // mode[1:0]
    // result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // dot_value[37:0], second_row[40:38],
                                                // first_row[43:41], zero pad
    output logic                m_axis_tlast,   // last_result
    // configuration write port
    input  logic                cfg_we,
    input  logic [CFGIDX_W-1:0] cfg_index,
    input  logic [CFGDAT_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_LEN;
    localparam int AW    = idx_width(DEPTH);
    localparam int IW    = idx_width(MAX_ROWS);      // row counter
    localparam int CW    = idx_width(MAX_LEN);       // column counter
    localparam int RW    = $clog2(MAX_ROWS + 1);     // clamped row count
    localparam int LW    = $clog2(MAX_LEN + 1);      // clamped length

    // ---------------- input unpacking ----------------
    logic [INDEX_W-1:0]        in_index;
    logic signed [VALUE_W-1:0] in_value;
    logic                      in_accept;
    logic                      in_range;

    assign in_index  = s_axis_tdata[INDEX_W-1:0];
    assign in_value  = s_axis_tdata[INDEX_W+VALUE_W-1:INDEX_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    // loads past the end of the store are dropped
    assign in_range  = 32'(in_index) < 32'(DEPTH);

    // ---------------- configuration registers ----------------
    logic [ROWCFG_W-1:0] rows_first_reg, rows_second_reg;
    logic [LENCFG_W-1:0] vec_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_first_reg  <= RST_ROWS_FIRST;
            rows_second_reg <= RST_ROWS_SECOND;
            vec_len_reg     <= RST_VEC_LEN;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ROWS_FIRST:    rows_first_reg  <= cfg_data[ROWCFG_W-1:0];
                CFG_ROWS_SECOND:   rows_second_reg <= cfg_data[ROWCFG_W-1:0];
                CFG_VECTOR_LENGTH: vec_len_reg     <= cfg_data[LENCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer state ----------------
    state_t        state_reg, state_next;
    logic [RW-1:0] nf_reg, ns_reg;         // clamped row counts of this run
    logic [LW-1:0] len_reg;                // clamped vector length of this run
    logic [IW-1:0] i_reg, j_reg;           // second row (outer), first row (inner)
    logic [CW-1:0] c_reg;                  // element within the row pair
    logic [AW-1:0] base_s_reg, base_f_reg; // row start addresses

    logic last_col, last_j, last_pair;
    logic out_free, put_fire;

    assign last_col  = c_reg == CW'(len_reg - LW'(1));
    assign last_j    = j_reg == IW'(nf_reg - RW'(1));
    assign last_pair = last_j && (i_reg == IW'(ns_reg - RW'(1)));

    assign out_free  = !m_axis_tvalid || m_axis_tready;
    assign put_fire  = (state_reg == ST_PUT) && out_free;

    logic mac_done;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && s_axis_tuser == MODE_COMPUTE) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (last_col) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                // leave once the accumulator has taken the last product
                if (mac_done) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (out_free) begin
                    state_next = last_pair ? ST_IDLE : ST_ISSUE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // counters and row bases
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_accept && s_axis_tuser == MODE_COMPUTE) begin
            nf_reg     <= RW'(clamp_cnt(32'(rows_first_reg), MAX_ROWS));
            ns_reg     <= RW'(clamp_cnt(32'(rows_second_reg), MAX_ROWS));
            len_reg    <= LW'(clamp_cnt(32'(vec_len_reg), MAX_LEN));
            i_reg      <= '0;
            j_reg      <= '0;
            c_reg      <= '0;
            base_s_reg <= '0;
            base_f_reg <= '0;
        end else if (state_reg == ST_ISSUE) begin
            c_reg <= last_col ? '0 : c_reg + CW'(1);
        end else if (put_fire && !last_pair) begin
            if (last_j) begin
                j_reg      <= '0;
                base_f_reg <= '0;
                i_reg      <= i_reg + IW'(1);
                base_s_reg <= base_s_reg + AW'(len_reg);
            end else begin
                j_reg      <= j_reg + IW'(1);
                base_f_reg <= base_f_reg + AW'(len_reg);
            end
        end
    end

    assign s_axis_tready = state_reg == ST_IDLE;

    // ---------------- element stores ----------------
    logic                  we_first, we_second;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [AW-1:0]         raddr_s, raddr_f;
    logic [DATA_WIDTH-1:0] rdata_s, rdata_f;

    assign we_first  = in_accept && in_range && s_axis_tuser == MODE_LOAD_FIRST;
    assign we_second = in_accept && in_range && s_axis_tuser == MODE_LOAD_SECOND;
    assign waddr     = AW'(in_index);
    assign wdata     = DATA_WIDTH'(in_value);
    assign raddr_s   = base_s_reg + AW'(c_reg);
    assign raddr_f   = base_f_reg + AW'(c_reg);

    mrdp_store #(.DEPTH(DEPTH), .DW(DATA_WIDTH), .AW(AW)) u_first_store (
        .aclk  (aclk),
        .we    (we_first),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_f),
        .rdata (rdata_f)
    );

    mrdp_store #(.DEPTH(DEPTH), .DW(DATA_WIDTH), .AW(AW)) u_second_store (
        .aclk  (aclk),
        .we    (we_second),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_s),
        .rdata (rdata_s)
    );

    // ---------------- shared multiply-accumulate ----------------
    mac_ctrl_t        ctrl_issue, ctrl_rd_reg;
    logic [DOT_W-1:0] mac_acc;

    assign ctrl_issue.vld   = state_reg == ST_ISSUE;
    assign ctrl_issue.first = c_reg == '0;
    assign ctrl_issue.last  = last_col;

    // control is registered alongside the registered store read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_rd_reg <= '0;
        end else begin
            ctrl_rd_reg <= ctrl_issue;
        end
    end

    mrdp_mac #(.DW(DATA_WIDTH)) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl_in (ctrl_rd_reg),
        .a       (rdata_s),
        .b       (rdata_f),
        .acc     (mac_acc),
        .done    (mac_done)
    );

    // ---------------- output register ----------------
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (put_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (put_fire) begin
            m_data_reg <= {M_PAD_W'(0), ROWF_W'(j_reg), ROWF_W'(i_reg), mac_acc};
            m_last_reg <= last_pair;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

@@ src/mrdp_checker.sv @@
module mrdp_checker import mrdp_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [S_USER_W-1:0] s_axis_tuser,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic                m_axis_tlast
);

    // no result straight after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a compute request closes the input until its run is done
    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_COMPUTE |=> !s_axis_tready)
        else $error("input still ready after compute request");

    // loads and unused modes keep the input open
    a_load_open: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != MODE_COMPUTE |=> s_axis_tready)
        else $error("input closed after load request");

    // while a run still has results to give, no new request is taken
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready in the middle of a run");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind matrix_row_dot_product_engine mrdp_checker u_mrdp_checker (.*);
